### src/c2s_pkg.sv
// shared types, constants and tables for the cartesian to spherical core
`default_nettype none

package c2s_pkg;

   // coordinate and angle formats
   localparam int COORD_BITS       = 16;
   localparam int ANGLE_ITERATIONS = 16;
   localparam int TURN_BITS        = 32;                      // accumulator units per turn, log2
   localparam int SCALE_SHIFT      = TURN_BITS - COORD_BITS;  // operand prescale
   localparam int ANGLE_BITS       = 16;
   localparam int ANGLE_FRAC       = TURN_BITS - ANGLE_BITS;

   // root chain
   localparam int SQ_BITS   = 2 * COORD_BITS;                 // square and sum of squares
   localparam int PEND_BITS = SQ_BITS;
   localparam int ROOT_BITS = (SQ_BITS + 2 * SCALE_SHIFT) / 2;
   localparam int REM_BITS  = ROOT_BITS + 4;

   // rotation chain
   localparam int VEC_BITS     = TURN_BITS + 4;
   localparam int ACC_BITS     = TURN_BITS + 2;
   localparam int ARC_BITS     = 32;
   localparam int TABLE_DEPTH  = 32;
   localparam int STEP_BITS    = $clog2(TABLE_DEPTH);
   localparam int CORDIC_STEPS =
      (ANGLE_ITERATIONS < TABLE_DEPTH) ? ANGLE_ITERATIONS : TABLE_DEPTH;

   // pipeline stage positions
   localparam int SUM_STAGE    = 2;
   localparam int ROOT_END     = SUM_STAGE + ROOT_BITS;
   localparam int PREROT_STAGE = ROOT_END + 1;
   localparam int PIPE_LAST    = PREROT_STAGE + CORDIC_STEPS;

   // result buffer
   localparam int OUT_DEPTH = 2;
   localparam logic [1:0] OUT_FULL = 2'(OUT_DEPTH);

   localparam logic signed [ACC_BITS-1:0] QUARTER_TURN =
      {{(ACC_BITS - TURN_BITS + 1){1'b0}}, 1'b1, {(TURN_BITS - 2){1'b0}}};
   localparam logic signed [ACC_BITS-1:0] ROUND_HALF =
      {{(ACC_BITS - ANGLE_FRAC){1'b0}}, 1'b1, {(ANGLE_FRAC - 1){1'b0}}};
   localparam logic [ANGLE_BITS-1:0] POLAR_MAX = {1'b1, {(ANGLE_BITS - 1){1'b0}}};

   // atan(2^-i) with 2^32 units per turn
   localparam logic [ARC_BITS-1:0] ARC_TABLE [TABLE_DEPTH] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
      32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
      32'h00000001, 32'h00000000
   };

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x_coord;
      logic signed [COORD_BITS-1:0] y_coord;
      logic signed [COORD_BITS-1:0] z_coord;
   } req_word_type;

   typedef struct packed {
      logic [COORD_BITS-1:0]        radius;
      logic signed [ANGLE_BITS-1:0] azimuth;
      logic [ANGLE_BITS-1:0]        polar_angle;
      logic                         at_origin;
   } rsp_word_type;

   typedef struct packed {
      logic [PEND_BITS-1:0] pend;
      logic [REM_BITS-1:0]  rem;
      logic [ROOT_BITS-1:0] root;
   } root_lane_type;

   typedef struct packed {
      logic signed [VEC_BITS-1:0] xv;
      logic signed [VEC_BITS-1:0] yv;
      logic signed [ACC_BITS-1:0] acc;
   } vec_lane_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] radius;
      logic                  phi_zero;
      logic                  at_origin;
   } side_type;

   function automatic logic [STEP_BITS-1:0] step_code(input int idx);
      return STEP_BITS'(idx);
   endfunction

endpackage

`default_nettype wire

### src/c2s_root_cell.sv
// one digit of the restoring square root chain
`default_nettype none

module c2s_root_cell (
   input  wire logic                   clock,
   input  wire logic                   advance,
   input  wire c2s_pkg::root_lane_type prev_lane,
   output c2s_pkg::root_lane_type      next_lane
);

   c2s_pkg::root_lane_type lane_ff, lane_in;
   logic [c2s_pkg::REM_BITS-1:0] shifted;
   logic [c2s_pkg::REM_BITS-1:0] trial;

   always_comb begin
      shifted = {prev_lane.rem[c2s_pkg::REM_BITS-3:0],
                 prev_lane.pend[c2s_pkg::PEND_BITS-1 -: 2]};
      trial   = {{(c2s_pkg::REM_BITS - c2s_pkg::ROOT_BITS - 2){1'b0}}, prev_lane.root, 2'b01};
      lane_in.pend = {prev_lane.pend[c2s_pkg::PEND_BITS-3:0], 2'b00};
      if (shifted >= trial) begin
         lane_in.rem  = shifted - trial;
         lane_in.root = {prev_lane.root[c2s_pkg::ROOT_BITS-2:0], 1'b1};
      end else begin
         lane_in.rem  = shifted;
         lane_in.root = {prev_lane.root[c2s_pkg::ROOT_BITS-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         lane_ff <= lane_in;
      end
   end

   assign next_lane = lane_ff;

endmodule

`default_nettype wire

### src/c2s_cordic_cell.sv
// one micro-rotation of a vectoring cordic
`default_nettype none

module c2s_cordic_cell (
   input  wire logic                          clock,
   input  wire logic                          advance,
   input  wire logic [c2s_pkg::STEP_BITS-1:0] step,
   input  wire c2s_pkg::vec_lane_type         prev_lane,
   output c2s_pkg::vec_lane_type              next_lane
);

   c2s_pkg::vec_lane_type lane_ff, lane_in;
   logic signed [c2s_pkg::VEC_BITS-1:0] dx;
   logic signed [c2s_pkg::VEC_BITS-1:0] dy;
   logic signed [c2s_pkg::ACC_BITS-1:0] arc;

   always_comb begin
      dx  = prev_lane.yv >>> step;
      dy  = prev_lane.xv >>> step;
      arc = {{(c2s_pkg::ACC_BITS - c2s_pkg::ARC_BITS){1'b0}}, c2s_pkg::ARC_TABLE[step]};
      // rotate toward the x axis, direction from the sign of y
      if (!prev_lane.yv[c2s_pkg::VEC_BITS-1]) begin
         lane_in.xv  = prev_lane.xv + dx;
         lane_in.yv  = prev_lane.yv - dy;
         lane_in.acc = prev_lane.acc + arc;
      end else begin
         lane_in.xv  = prev_lane.xv - dx;
         lane_in.yv  = prev_lane.yv + dy;
         lane_in.acc = prev_lane.acc - arc;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         lane_ff <= lane_in;
      end
   end

   assign next_lane = lane_ff;

endmodule

`default_nettype wire

### src/cartesian_to_spherical_core.sv
// top level of the cartesian to spherical core
`default_nettype none

// Converts a point (x, y, z) of signed 16-bit integers to radius, azimuth and polar angle,
// angles in binary units with 32768 for pi. One word is taken every clock cycle while
// req_stall is low. A word passes through two parallel chains of 32 square root cells
// (one root bit each), then two parallel chains of 16 cordic cells (one micro-rotation
// each), plus the squaring, summing and quadrant stages. A two-word output buffer keeps
// input flowing while a result waits; only when the buffer is full and the last stage
// holds a word does req_stall rise, and then the whole chain holds.

module cartesian_to_spherical_core (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire c2s_pkg::req_word_type req_word,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output c2s_pkg::rsp_word_type      rsp_word
);

   function automatic logic signed [c2s_pkg::VEC_BITS-1:0] scale_coord(
      input logic signed [c2s_pkg::COORD_BITS-1:0] c
   );
      return {{(c2s_pkg::VEC_BITS - c2s_pkg::COORD_BITS - c2s_pkg::SCALE_SHIFT)
               {c[c2s_pkg::COORD_BITS-1]}}, c, {c2s_pkg::SCALE_SHIFT{1'b0}}};
   endfunction

   // turn a left half-plane vector by a quarter so the cordic converges
   function automatic c2s_pkg::vec_lane_type prerotate(
      input logic signed [c2s_pkg::VEC_BITS-1:0] yy,
      input logic signed [c2s_pkg::VEC_BITS-1:0] xx
   );
      c2s_pkg::vec_lane_type v;
      v.xv  = xx;
      v.yv  = yy;
      v.acc = '0;
      if (xx[c2s_pkg::VEC_BITS-1]) begin
         if (!yy[c2s_pkg::VEC_BITS-1]) begin
            v.xv  = yy;
            v.yv  = -xx;
            v.acc = c2s_pkg::QUARTER_TURN;
         end else begin
            v.xv  = -yy;
            v.yv  = xx;
            v.acc = -c2s_pkg::QUARTER_TURN;
         end
      end
      return v;
   endfunction

   logic advance;
   logic push;
   logic pop;

   logic [c2s_pkg::PIPE_LAST:0] vld_ff, vld_in;
   logic [1:0] count_ff, count_in;

   c2s_pkg::req_word_type coord_ff [0:c2s_pkg::ROOT_END];

   logic [c2s_pkg::SQ_BITS-1:0] xsq_ff, ysq_ff, zsq_ff;
   logic [c2s_pkg::SQ_BITS-1:0] xsq_in, ysq_in, zsq_in;
   logic [c2s_pkg::SQ_BITS-1:0] planar_ff, sum_ff, planar_in, sum_in;

   c2s_pkg::root_lane_type sum_lane [0:c2s_pkg::ROOT_BITS];
   c2s_pkg::root_lane_type rho_lane [0:c2s_pkg::ROOT_BITS];

   c2s_pkg::req_word_type         pre_coord;
   logic [c2s_pkg::ROOT_BITS-1:0] sum_root;
   logic [c2s_pkg::ROOT_BITS-1:0] rho_root;

   c2s_pkg::vec_lane_type phi0_ff, theta0_ff, phi0_in, theta0_in;
   c2s_pkg::vec_lane_type phi_lane   [0:c2s_pkg::CORDIC_STEPS];
   c2s_pkg::vec_lane_type theta_lane [0:c2s_pkg::CORDIC_STEPS];
   c2s_pkg::side_type     side_ff    [0:c2s_pkg::CORDIC_STEPS];
   c2s_pkg::side_type     side0_in;

   c2s_pkg::vec_lane_type phi_end;
   c2s_pkg::vec_lane_type theta_end;
   c2s_pkg::side_type     side_end;
   logic signed [c2s_pkg::ACC_BITS-1:0]            phi_round;
   logic signed [c2s_pkg::ACC_BITS-1:0]            theta_round;
   logic signed [c2s_pkg::ACC_BITS-c2s_pkg::ANGLE_FRAC-1:0] theta_q;
   c2s_pkg::rsp_word_type result;

   c2s_pkg::rsp_word_type out0_ff, out1_ff, out0_in, out1_in;
   logic                  slot_one;

   // handshake and chain control
   assign advance   = !vld_ff[c2s_pkg::PIPE_LAST] || (count_ff != c2s_pkg::OUT_FULL);
   assign req_stall = !advance;
   assign push      = advance && vld_ff[c2s_pkg::PIPE_LAST];
   assign rsp_valid = (count_ff != 2'd0);
   assign pop       = rsp_valid && !rsp_stall;
   assign vld_in    = {vld_ff[c2s_pkg::PIPE_LAST-1:0], req_valid};

   // squares and sums
   assign xsq_in    = coord_ff[0].x_coord * coord_ff[0].x_coord;
   assign ysq_in    = coord_ff[0].y_coord * coord_ff[0].y_coord;
   assign zsq_in    = coord_ff[0].z_coord * coord_ff[0].z_coord;
   assign planar_in = xsq_ff + ysq_ff;
   assign sum_in    = xsq_ff + ysq_ff + zsq_ff;

   // both radicands are taken with a 2^(2*scale) fraction below them
   assign sum_lane[0] = '{pend: sum_ff, rem: '0, root: '0};
   assign rho_lane[0] = '{pend: planar_ff, rem: '0, root: '0};

   for (genvar k = 0; k < c2s_pkg::ROOT_BITS; k++) begin : g_root
      c2s_root_cell u_sum_cell (
         .clock     (clock),
         .advance   (advance),
         .prev_lane (sum_lane[k]),
         .next_lane (sum_lane[k+1])
      );
      c2s_root_cell u_rho_cell (
         .clock     (clock),
         .advance   (advance),
         .prev_lane (rho_lane[k]),
         .next_lane (rho_lane[k+1])
      );
   end

   // quadrant stage
   assign pre_coord = coord_ff[c2s_pkg::ROOT_END];
   assign sum_root  = sum_lane[c2s_pkg::ROOT_BITS].root;
   assign rho_root  = rho_lane[c2s_pkg::ROOT_BITS].root;

   always_comb begin
      phi0_in   = prerotate(scale_coord(pre_coord.y_coord), scale_coord(pre_coord.x_coord));
      theta0_in = prerotate({{(c2s_pkg::VEC_BITS - c2s_pkg::ROOT_BITS){1'b0}}, rho_root},
                            scale_coord(pre_coord.z_coord));
      // fraction bit below the integer root decides the rounding
      side0_in.radius    = sum_root[c2s_pkg::ROOT_BITS-1:c2s_pkg::SCALE_SHIFT]
                           + {{(c2s_pkg::COORD_BITS - 1){1'b0}},
                              sum_root[c2s_pkg::SCALE_SHIFT-1]};
      side0_in.phi_zero  = (pre_coord.x_coord == '0) && (pre_coord.y_coord == '0);
      side0_in.at_origin = (sum_root == '0);
   end

   assign phi_lane[0]   = phi0_ff;
   assign theta_lane[0] = theta0_ff;

   for (genvar i = 0; i < c2s_pkg::CORDIC_STEPS; i++) begin : g_cordic
      c2s_cordic_cell u_phi_cell (
         .clock     (clock),
         .advance   (advance),
         .step      (c2s_pkg::step_code(i)),
         .prev_lane (phi_lane[i]),
         .next_lane (phi_lane[i+1])
      );
      c2s_cordic_cell u_theta_cell (
         .clock     (clock),
         .advance   (advance),
         .step      (c2s_pkg::step_code(i)),
         .prev_lane (theta_lane[i]),
         .next_lane (theta_lane[i+1])
      );
   end

   // rounding and clamping of the last stage
   assign phi_end   = phi_lane[c2s_pkg::CORDIC_STEPS];
   assign theta_end = theta_lane[c2s_pkg::CORDIC_STEPS];
   assign side_end  = side_ff[c2s_pkg::CORDIC_STEPS];

   always_comb begin
      phi_round   = phi_end.acc + c2s_pkg::ROUND_HALF;
      theta_round = theta_end.acc + c2s_pkg::ROUND_HALF;
      theta_q     = theta_round[c2s_pkg::ACC_BITS-1:c2s_pkg::ANGLE_FRAC];

      result.radius    = side_end.radius;
      result.at_origin = side_end.at_origin;
      result.azimuth   = phi_round[c2s_pkg::TURN_BITS-1:c2s_pkg::ANGLE_FRAC];
      if (theta_q[c2s_pkg::ACC_BITS-c2s_pkg::ANGLE_FRAC-1]) begin
         result.polar_angle = '0;
      end else if (theta_q[c2s_pkg::ACC_BITS-c2s_pkg::ANGLE_FRAC-2:0] >
                   {{(c2s_pkg::ACC_BITS - c2s_pkg::ANGLE_FRAC - 1 - c2s_pkg::ANGLE_BITS){1'b0}},
                    c2s_pkg::POLAR_MAX}) begin
         result.polar_angle = c2s_pkg::POLAR_MAX;
      end else begin
         result.polar_angle = theta_q[c2s_pkg::ANGLE_BITS-1:0];
      end
      if (side_end.phi_zero || side_end.at_origin) begin
         result.azimuth = '0;
      end
      if (side_end.at_origin) begin
         result.polar_angle = '0;
      end
   end

   // two-word output buffer, head in out0
   always_comb begin
      slot_one = (count_ff == 2'd1) && !pop;
      out0_in  = out0_ff;
      out1_in  = out1_ff;
      count_in = count_ff;
      if (pop) begin
         out0_in = out1_ff;
      end
      if (push) begin
         if (slot_one) begin
            out1_in = result;
         end else begin
            out0_in = result;
         end
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push && pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   assign rsp_word = out0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= '0;
         count_ff <= '0;
      end else begin
         if (advance) begin
            vld_ff <= vld_in;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         coord_ff[0] <= req_word;
         for (int k = 1; k <= c2s_pkg::ROOT_END; k++) begin
            coord_ff[k] <= coord_ff[k-1];
         end
         xsq_ff    <= xsq_in;
         ysq_ff    <= ysq_in;
         zsq_ff    <= zsq_in;
         planar_ff <= planar_in;
         sum_ff    <= sum_in;
         phi0_ff   <= phi0_in;
         theta0_ff <= theta0_in;
         side_ff[0] <= side0_in;
         for (int j = 1; j <= c2s_pkg::CORDIC_STEPS; j++) begin
            side_ff[j] <= side_ff[j-1];
         end
      end
      out0_ff <= out0_in;
      out1_ff <= out1_in;
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != c2s_pkg::OUT_FULL))
      else $error("result pushed into a full output buffer");

   a_open_when_room: assert property (@(posedge clock) disable iff (reset)
      (count_ff != c2s_pkg::OUT_FULL) |-> !req_stall)
      else $error("input stalled while the output buffer has room");

   a_chain_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(vld_ff))
      else $error("pipeline moved while held");

   a_origin_angles: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.at_origin) |->
         (rsp_word.azimuth == '0) && (rsp_word.polar_angle == '0))
      else $error("nonzero angle at the origin");

   a_polar_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word.polar_angle <= c2s_pkg::POLAR_MAX))
      else $error("polar angle beyond pi");

endmodule

`default_nettype wire

### bench/tb_cartesian_to_spherical_core.sv
// self-checking testbench for the cartesian to spherical core
`timescale 1ns / 1ps

module tb_cartesian_to_spherical_core;

   localparam int     ROTATIONS     = c2s_pkg::ANGLE_ITERATIONS;
   localparam longint QUARTER_UNITS = 64'sd1073741824;
   localparam int     HOLD_CYCLES   = 200;
   localparam int     DRAIN_CYCLES  = 60;
   localparam int     STUCK_LIMIT   = 2000;

   // atan(2^-i), 2^32 units per turn
   localparam longint ARCTAN_UNITS [32] = '{
      'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
      'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
      'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
      'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051,
      'h00000029, 'h00000014, 'h0000000A, 'h00000005, 'h00000003, 'h00000001,
      'h00000001, 'h00000000
   };

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   c2s_pkg::req_word_type req_word;
   logic                  rsp_valid;
   logic                  rsp_stall;
   c2s_pkg::rsp_word_type rsp_word;

   c2s_pkg::req_word_type point_q[$];
   c2s_pkg::rsp_word_type sph_expect_q[$];

   int  send_idle_pct = 19;
   int  recv_idle_pct = 52;
   int  hold_requests = 0;
   int  hold_seen     = 0;
   int  hold_left     = 0;
   int  stuck_cycles  = 0;
   int  points_sent   = 0;
   int  results_checked = 0;
   int  mismatch_count  = 0;
   bit  req_taken     = 1'b0;

   cartesian_to_spherical_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic longint unsigned isqrt64(input longint unsigned n);
      longint unsigned root;
      longint unsigned bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   // vectoring cordic, atan2(yy, xx) with 2^32 units per turn
   function automatic longint vector_angle(input longint yy, input longint xx);
      longint acc;
      longint t;
      longint dx;
      longint dy;
      acc = 0;
      if (xx == 0 && yy == 0) return 0;
      if (xx < 0) begin
         t = xx;
         if (yy >= 0) begin
            xx = yy;
            yy = -t;
            acc = QUARTER_UNITS;
         end else begin
            xx = -yy;
            yy = t;
            acc = -QUARTER_UNITS;
         end
      end
      for (int i = 0; i < ROTATIONS && i < 32; i++) begin
         dx = yy >>> i;
         dy = xx >>> i;
         if (yy >= 0) begin
            xx += dx;
            yy -= dy;
            acc += ARCTAN_UNITS[i];
         end else begin
            xx -= dx;
            yy += dy;
            acc -= ARCTAN_UNITS[i];
         end
      end
      return acc;
   endfunction

   function automatic c2s_pkg::rsp_word_type spherical_of(input c2s_pkg::req_word_type p);
      longint                x;
      longint                y;
      longint                z;
      longint                phi;
      longint                theta;
      longint unsigned       planar;
      longint unsigned       total;
      longint unsigned       r;
      longint unsigned       rho;
      c2s_pkg::rsp_word_type w;
      x = longint'(p.x_coord);
      y = longint'(p.y_coord);
      z = longint'(p.z_coord);
      planar = x * x + y * y;
      total  = planar + z * z;
      r = isqrt64(total);
      if (total - r * r > r) r++;
      w = '0;
      if (total == 0) begin
         w.at_origin = 1'b1;
         return w;
      end
      phi   = vector_angle(y * 65536, x * 65536);
      rho   = isqrt64(planar << 32);
      theta = vector_angle(longint'(rho), z * 65536);
      theta = (theta + 32768) >>> 16;
      if (theta < 0) theta = 0;
      if (theta > 32768) theta = 32768;
      phi = (phi + 32768) >>> 16;
      w.radius      = r[15:0];
      w.azimuth     = phi[15:0];
      w.polar_angle = theta[15:0];
      return w;
   endfunction

   function automatic c2s_pkg::req_word_type random_point();
      c2s_pkg::req_word_type p;
      int                    corner [7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};
      p = c2s_pkg::req_word_type'({$urandom(), 16'($urandom())});
      case ($urandom_range(0, 9))
         4, 5: begin
            p.x_coord = 16'(int'($urandom_range(0, 16)) - 8);
            p.y_coord = 16'(int'($urandom_range(0, 16)) - 8);
            p.z_coord = 16'(int'($urandom_range(0, 16)) - 8);
         end
         6: begin
            // each coordinate zeroed at random: points on an axis or in a coordinate plane
            if ($urandom_range(0, 1)) p.x_coord = '0;
            if ($urandom_range(0, 1)) p.y_coord = '0;
            if ($urandom_range(0, 1)) p.z_coord = '0;
         end
         7: begin
            p.x_coord = 16'(corner[$urandom_range(0, 6)]);
            p.y_coord = 16'(corner[$urandom_range(0, 6)]);
            p.z_coord = 16'(corner[$urandom_range(0, 6)]);
         end
         8: p.x_coord = 16'(-int'($urandom_range(1, 32768)));
         default: ;
      endcase
      return p;
   endfunction

   task automatic queue_point(input int x, input int y, input int z);
      c2s_pkg::req_word_type p;
      p.x_coord = 16'(x);
      p.y_coord = 16'(y);
      p.z_coord = 16'(z);
      point_q.push_back(p);
   endtask

   // look just after the falling edge so the sender's updates have landed
   task automatic wait_drained();
      while (point_q.size() != 0 || req_valid || sph_expect_q.size() != 0) begin
         @(negedge clock);
         #1;
      end
   endtask

   // sender
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (point_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_word  <= point_q.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver, with an occasional long hold-off
   always @(negedge clock) begin
      if (hold_seen != hold_requests) begin
         hold_seen = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   // checker and watchdog
   always @(posedge clock) begin
      c2s_pkg::rsp_word_type want;
      bit                    rsp_taken;
      req_taken = !reset && req_valid && !req_stall;
      rsp_taken = !reset && rsp_valid && !rsp_stall;
      if (rsp_taken) begin
         if (sph_expect_q.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected result word r=%0d az=%0d pol=%0d org=%0b", $time,
                     rsp_word.radius, rsp_word.azimuth, rsp_word.polar_angle,
                     rsp_word.at_origin);
         end else begin
            want = sph_expect_q.pop_front();
            results_checked++;
            if (rsp_word.radius !== want.radius || rsp_word.azimuth !== want.azimuth ||
                rsp_word.polar_angle !== want.polar_angle ||
                rsp_word.at_origin !== want.at_origin) begin
               mismatch_count++;
               $display("%0t: exp r=%0d az=%0d pol=%0d org=%0b got r=%0d az=%0d pol=%0d org=%0b",
                        $time, want.radius, want.azimuth, want.polar_angle, want.at_origin,
                        rsp_word.radius, rsp_word.azimuth, rsp_word.polar_angle,
                        rsp_word.at_origin);
            end
         end
      end
      if (req_taken) begin
         sph_expect_q.push_back(spherical_of(req_word));
         points_sent++;
      end
      if (req_taken || rsp_taken) begin
         stuck_cycles = 0;
      end else begin
         stuck_cycles++;
         if (stuck_cycles == STUCK_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, STUCK_LIMIT);
            $display("Mismatches found");
            $finish;
         end
      end
   end

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_word  = '0;
      rsp_stall = 1'b0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // origin, corners, axes and the quadrant turns
      queue_point(0, 0, 0);
      queue_point(32767, 32767, 32767);
      queue_point(-32768, -32768, -32768);
      queue_point(-32768, 32767, -32768);
      queue_point(32767, -32768, 32767);
      queue_point(0, 0, 1);
      queue_point(0, 0, -1);
      queue_point(0, 0, 32767);
      queue_point(0, 0, -32768);
      queue_point(1, 0, 0);
      queue_point(-1, 0, 0);
      queue_point(0, 1, 0);
      queue_point(0, -1, 0);
      queue_point(-1, -1, 0);
      queue_point(-1, 1, 0);
      queue_point(-32768, 0, 0);
      queue_point(0, -32768, 0);
      queue_point(32767, 0, -32768);
      queue_point(-5, 0, -3);
      queue_point(1, 1, -32768);
      queue_point(3, 4, 0);
      wait_drained();

      repeat (180) point_q.push_back(random_point());
      wait_drained();

      send_idle_pct = 52;
      recv_idle_pct = 19;
      repeat (180) point_q.push_back(random_point());
      wait_drained();

      // back to back, with the output held long enough to back up the pipe
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (190) point_q.push_back(random_point());
      hold_requests++;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("converted %0d points, %0d results checked", points_sent, results_checked);
      $display("covered origin, axes, corners and random points under three stall mixes");
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
